@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/stt_pkg.sv @@
// Package for the second timer table: commands, field widths, defaults.
package stt_pkg;

  localparam int unsigned TIMER_COUNT_DEF = 16;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned SEC_W   = 32;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ARM     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

endpackage

@@ rtl/core/second_timer_table_unit.sv @@
// Second timer table: one-shot timers with a one-second tick and a sequential scan.
//
//  channel | dir | tvalid/tready | tuser          | tdata
//  in_     | in  | handshake     | command [1:0]  | timer_id [3:0], delay_seconds [19:4]
//  out_    | out | handshake     | fired [0]      | expired_id [3:0], status [4]; tlast=last
//
// Create, arm and destroy pass from accept to the flush state, which registers
// their result once the output register is free and makes the input ready again.
// A tick scans every entry before the flush state registers its final result: the scan
// reads one expiry word per cycle from the expiry memory, unless stalled, and compares
// it against the second counter; the flush state then makes the input ready again.
// Reset clears the second counter, the active bits and all handshake state.
// A full output register stalls the scan only when a second match is waiting.
`include "assert_macros.svh"

module second_timer_table_unit
  import stt_pkg::*;
#(
  parameter int unsigned TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // timer_id [3:0], delay_seconds [19:4]
  input  logic [CMD_W-1:0]      in_tuser,   // command [1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // expired_id [3:0], status [4]
  output logic                  out_tuser,  // fired [0]
  output logic                  out_tlast
);

  localparam int unsigned AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned CW = $clog2(TIMER_COUNT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [SEC_W-1:0]       now_r;
  logic [TIMER_COUNT-1:0] active_r;
  logic [SEC_W-1:0]       expiry_mem [TIMER_COUNT];

  logic [CW-1:0]          idx_r;       // next entry to read
  logic                   cmp_v_r;     // compare stage holds a read word
  logic [AW-1:0]          cmp_id_r;
  logic [SEC_W-1:0]       rd_r;
  logic                   pend_v_r;    // a match waiting for its last flag
  logic [AW-1:0]          pend_id_r;
  logic                   status_r;

  logic                   out_v_r;
  logic                   out_fired_r;
  logic [ID_W-1:0]        out_id_r;
  logic                   out_status_r;
  logic                   out_last_r;

  logic [ID_W-1:0]        in_timer_id;
  logic [DELAY_W-1:0]     in_delay;
  logic [AW-1:0]          tid;
  logic                   in_acc;
  logic                   id_ok;
  logic                   out_free;
  logic                   issue_done;
  logic                   match;
  logic                   stall;
  logic                   advance;
  logic                   emit_mid;
  logic                   emit_last;

  assign in_timer_id = in_tdata[ID_W-1:0];
  assign in_delay    = in_tdata[ID_W +: DELAY_W];
  assign tid         = AW'(in_timer_id);
  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign id_ok       = ({{(SEC_W-ID_W){1'b0}}, in_timer_id} < SEC_W'(TIMER_COUNT));
  assign out_free    = !out_v_r || out_tready;
  assign issue_done  = (idx_r == CW'(TIMER_COUNT));
  assign match       = cmp_v_r && active_r[cmp_id_r] && (rd_r == now_r);
  // a second match must push the held one out, which needs a free output slot
  assign stall       = match && pend_v_r && !out_free;
  assign advance     = (state_r == ST_SCAN) && !stall;
  assign emit_mid    = advance && match && pend_v_r;
  assign emit_last   = (state_r == ST_FLUSH) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == CMD_TICK) ? ST_SCAN : ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (issue_done && !cmp_v_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // expiry memory: write on create/arm, registered read during the scan
  always_ff @(posedge clk) begin
    if (in_acc && id_ok) begin
      if (in_tuser == CMD_CREATE) begin
        expiry_mem[tid] <= now_r;
      end else if (in_tuser == CMD_ARM && active_r[tid]) begin
        expiry_mem[tid] <= now_r + {{(SEC_W-DELAY_W){1'b0}}, in_delay};
      end
    end
    if (advance && !issue_done) begin
      rd_r <= expiry_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      now_r    <= '0;
      active_r <= '0;
      idx_r    <= '0;
      cmp_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_mid || emit_last) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end

      if (in_acc) begin
        if (in_tuser == CMD_TICK) begin
          now_r <= now_r + 1'b1;
          idx_r <= '0;
          cmp_v_r <= 1'b0;
        end else if (id_ok) begin
          if (in_tuser == CMD_CREATE) begin
            active_r[tid] <= 1'b1;
          end else if (in_tuser == CMD_DESTROY) begin
            active_r[tid] <= 1'b0;
          end
        end
      end

      if (advance) begin
        if (match) begin
          if (pend_v_r) begin
            out_fired_r  <= 1'b1;
            out_id_r     <= ID_W'(pend_id_r);
            out_status_r <= STATUS_OK;
            out_last_r   <= 1'b0;
          end
          pend_v_r  <= 1'b1;
          pend_id_r <= cmp_id_r;
        end
        if (!issue_done) begin
          cmp_v_r  <= 1'b1;
          cmp_id_r <= idx_r[AW-1:0];
          idx_r    <= idx_r + 1'b1;
        end else begin
          cmp_v_r <= 1'b0;
        end
      end

      if (emit_last) begin
        out_fired_r  <= pend_v_r;
        out_id_r     <= pend_v_r ? ID_W'(pend_id_r) : '0;
        out_status_r <= status_r;
        out_last_r   <= 1'b1;
        pend_v_r     <= 1'b0;
      end
    end
  end

  // result status of the accepted command; a tick always reports accepted
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_tuser == CMD_TICK || (id_ok && in_tuser == CMD_CREATE)) begin
        status_r <= STATUS_OK;
      end else if (id_ok && active_r[tid]) begin
        status_r <= STATUS_OK;
      end else begin
        status_r <= STATUS_IGNORED;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_fired_r;
  assign out_tdata  = {{(OUT_DATA_W-ID_W-1){1'b0}}, out_status_r, out_id_r};
  assign out_tlast  = out_last_r;

  `ASSERT_CLK(a_tick_advances, clk, rst_n,
    in_acc && in_tuser == CMD_TICK |=> now_r == $past(now_r) + 1'b1,
    "tick did not advance the second counter")
  `ASSERT_CLK(a_stall_holds_scan, clk, rst_n,
    state_r == ST_SCAN && stall |=> $stable(idx_r) && $stable(pend_id_r),
    "scan moved while stalled")
  `ASSERT_CLK(a_pend_only_busy, clk, rst_n,
    pend_v_r |-> state_r != ST_IDLE,
    "held match left behind after the scan")
  `ASSERT_CLK(a_flush_emits_last, clk, rst_n,
    state_r == ST_FLUSH && out_free |=> out_tvalid && out_tlast,
    "final result of an item not marked last")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the second timer table: random command streams with stalls.
`timescale 1ns / 1ps

module tb;
  import stt_pkg::*;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
  } timer_cmd_t;

  typedef struct {
    logic            fired;
    logic [ID_W-1:0] exp_id;
    logic            status;
    logic            is_last;
  } timer_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // timer_id [3:0], delay_seconds [19:4]
  logic [CMD_W-1:0]      in_tuser = '0;   // command [1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // expired_id [3:0], status [4]
  logic                  out_tuser;       // fired [0]
  logic                  out_tlast;

  second_timer_table_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // timer table mirror
  logic [SEC_W-1:0] sec_now = '0;
  logic [SEC_W-1:0] expiry_tab [TIMER_COUNT_DEF];
  logic             active_tab [TIMER_COUNT_DEF];

  timer_cmd_t    cmd_q[$];
  timer_result_t timer_results_q[$];
  int            err_cnt = 0;
  int            accepted_cnt = 0;
  int            gen_cnt = 0;

  initial begin
    for (int i = 0; i < TIMER_COUNT_DEF; i++) begin
      expiry_tab[i] = '0;
      active_tab[i] = 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int id, input int delay);
    timer_cmd_t c;
    c.cmd   = cmd;
    c.id    = id[ID_W-1:0];
    c.delay = delay[DELAY_W-1:0];
    cmd_q.push_back(c);
    gen_cnt++;
  endtask

  // Updates the mirror and queues the results this command produces.
  task automatic apply_timer_cmd(input timer_cmd_t c);
    timer_result_t r;
    int            last_hit;
    logic          st;
    r.fired   = 1'b0;
    r.exp_id  = '0;
    r.status  = STATUS_OK;
    r.is_last = 1'b1;
    if (c.cmd == CMD_TICK) begin
      sec_now  = sec_now + 1;
      last_hit = -1;
      for (int i = 0; i < TIMER_COUNT_DEF; i++)
        if (active_tab[i] && expiry_tab[i] == sec_now) last_hit = i;
      if (last_hit < 0) begin
        timer_results_q.push_back(r);
      end else begin
        for (int i = 0; i <= last_hit; i++) begin
          if (active_tab[i] && expiry_tab[i] == sec_now) begin
            r.fired   = 1'b1;
            r.exp_id  = i[ID_W-1:0];
            r.is_last = (i == last_hit);
            timer_results_q.push_back(r);
          end
        end
      end
    end else begin
      st = STATUS_OK;
      if (c.id >= TIMER_COUNT_DEF) begin
        st = STATUS_IGNORED;
      end else if (c.cmd == CMD_CREATE) begin
        active_tab[c.id] = 1'b1;
        expiry_tab[c.id] = sec_now;
      end else if (!active_tab[c.id]) begin
        st = STATUS_IGNORED;
      end else if (c.cmd == CMD_ARM) begin
        expiry_tab[c.id] = sec_now + c.delay;
      end else begin
        active_tab[c.id] = 1'b0;
      end
      r.status = st;
      timer_results_q.push_back(r);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  timer_cmd_t cur_cmd;
  int         burst_left = 0;
  int         gap_left = 0;

  always @(posedge clk) begin : drive_p
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_timer_cmd(cur_cmd);
        accepted_cnt++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          nxt_valid = 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          burst_left--;
          nxt_valid = 1'b1;
          in_tdata  <= {{(IN_DATA_W - DELAY_W - ID_W){1'b0}}, cur_cmd.delay, cur_cmd.id};
          in_tuser  <= cur_cmd.cmd;
        end else begin
          nxt_valid = 1'b0;
        end
      end
    end
    in_tvalid <= nxt_valid;
  end

  // Receiver: stall pattern drawn at random from four modes; two long hold-offs.
  int rx_cyc = 0;
  int rx_mode = 0;
  int hold_left = 0;
  int hold_idx = 0;

  always @(posedge clk) begin : recv_p
    logic rdy;
    rdy = 1'b1;
    if (rst_n) begin
      rx_cyc++;
      if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_idx < 2 && accepted_cnt >= 60 + 140 * hold_idx) begin
        hold_left = 300;
        hold_idx++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          2: rdy = (rx_cyc % 4 == 0);
          default: rdy = ($urandom_range(0, 7) != 0);
        endcase
      end
    end else begin
      rdy = 1'b0;
    end
    out_tready <= rdy;
  end

  // Result checker
  always @(posedge clk) begin : check_p
    timer_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (timer_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result fired=%0b id=%0d status=%0b last=%0b",
                                  out_tuser, out_tdata[3:0], out_tdata[4], out_tlast));
      end else begin
        e = timer_results_q.pop_front();
        if (out_tuser !== e.fired || out_tdata[3:0] !== e.exp_id ||
            out_tdata[4] !== e.status || out_tlast !== e.is_last)
          report_mismatch($sformatf(
            "got fired=%0b id=%0d status=%0b last=%0b, want %0b/%0d/%0b/%0b",
            out_tuser, out_tdata[3:0], out_tdata[4], out_tlast,
            e.fired, e.exp_id, e.status, e.is_last));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stim_p
    int sel, k, d, base;
    // directed part
    queue_cmd(CMD_TICK, 0, 0);          // tick with nothing active
    queue_cmd(CMD_ARM, 5, 3);           // arm of an inactive timer
    queue_cmd(CMD_DESTROY, 5, 0);       // destroy of an inactive timer
    queue_cmd(CMD_CREATE, 0, 0);
    queue_cmd(CMD_CREATE, 15, 0);
    queue_cmd(CMD_ARM, 0, 1);
    queue_cmd(CMD_ARM, 15, 1);
    queue_cmd(CMD_TICK, 0, 0);          // both fire, ascending
    queue_cmd(CMD_TICK, 0, 0);          // they stay active but do not fire again
    queue_cmd(CMD_CREATE, 15, 0);       // create while active
    queue_cmd(CMD_ARM, 0, 0);           // zero delay: never fires here
    queue_cmd(CMD_ARM, 15, 65535);
    queue_cmd(CMD_CREATE, 10, 0);
    queue_cmd(CMD_ARM, 10, 2);
    queue_cmd(CMD_CREATE, 5, 0);
    queue_cmd(CMD_ARM, 5, 4);
    queue_cmd(CMD_ARM, 5, 2);           // re-armed earlier than before
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_TICK, 0, 0);          // fires 5 and 10
    queue_cmd(CMD_DESTROY, 10, 0);
    queue_cmd(CMD_DESTROY, 10, 0);      // now inactive
    queue_cmd(CMD_ARM, 10, 1);
    queue_cmd(CMD_ARM, 5, 1);
    queue_cmd(CMD_TICK, 0, 0);

    // every timer expiring on the same tick
    for (int i = 0; i < TIMER_COUNT_DEF; i++) begin
      queue_cmd(CMD_CREATE, i, 0);
      queue_cmd(CMD_ARM, i, 1);
    end
    queue_cmd(CMD_TICK, 0, 0);

    while (gen_cnt < 255) begin
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        // well-formed group: create and arm a set, then tick up to expiry
        k    = $urandom_range(1, 16);
        d    = $urandom_range(1, 5);
        base = $urandom_range(0, 15);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 3) != 0) queue_cmd(CMD_CREATE, (base + i) % 16, 0);
          queue_cmd(CMD_ARM, (base + i) % 16, $urandom_range(0, 4) == 0 ? d + 2 : d);
          if ($urandom_range(0, 5) == 0) queue_cmd(CMD_ARM, (base + i) % 16, d);
          if ($urandom_range(0, 7) == 0) queue_cmd(CMD_DESTROY, (base + i) % 16, 0);
        end
        for (int i = 0; i < d + 2; i++) queue_cmd(CMD_TICK, 0, 0);
      end else begin
        // a run of four random commands
        for (int j = 0; j < 4; j++) begin
          sel = $urandom_range(0, 99);
          if (sel < 35)
            queue_cmd(CMD_TICK, 0, $urandom_range(0, 65535));
          else if (sel < 50)
            queue_cmd(CMD_CREATE, $urandom_range(0, 15), $urandom_range(0, 65535));
          else if (sel < 80)
            queue_cmd(CMD_ARM, $urandom_range(0, 15),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 6));
          else
            queue_cmd(CMD_DESTROY, $urandom_range(0, 15), $urandom_range(0, 65535));
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || in_tvalid) @(posedge clk);
    while (timer_results_q.size() > 0) @(posedge clk);
    repeat (4 * TIMER_COUNT_DEF) @(posedge clk);

    if (err_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
